/* design/e2g_pkg.sv */
// ----------------------------------------------------------------------------
// e2g_pkg: shared constants and types for the ECEF to geodetic converter
// Ellipsoid constants, fixed-point scales and CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2g_pkg;

  localparam int MaxIterationsDefault = 8;
  localparam int CordicStagesDefault  = 32;

  localparam logic signed [63:0] OneQ30    = 64'sd1073741824;
  localparam logic signed [63:0] PiQ30     = 64'sd3373259426;
  localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;
  localparam logic signed [63:0] InvKQ30   = 64'sd652032874;
  localparam logic [63:0]        E2Q32     = 64'd28752143;
  localparam logic signed [63:0] AQ8       = 64'sd1632803072000;
  localparam logic signed [63:0] BMm       = 64'sd6356752314;
  localparam logic signed [63:0] SqrtAbQ8  = 64'sd1630063534080;
  localparam logic signed [63:0] Lim40     = 64'sd549755813887;

  localparam logic [0:0] CfgHeightTol = 1'b0;
  localparam logic [0:0] CfgLatTol    = 1'b1;

  typedef struct packed {
    logic        start;
    logic        vec_mode;
    logic signed [63:0] x0;
    logic signed [63:0] y0;
    logic signed [63:0] z0;
  } cordic_req_t;

  typedef struct packed {
    logic        done;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cordic_rsp_t;

  function automatic logic signed [63:0] atan_q30(input logic [5:0] i);
    logic signed [63:0] r;
    case (i)
      6'd0:  r = 64'sd843314857;
      6'd1:  r = 64'sd497837829;
      6'd2:  r = 64'sd263043837;
      6'd3:  r = 64'sd133525159;
      6'd4:  r = 64'sd67021687;
      6'd5:  r = 64'sd33543516;
      6'd6:  r = 64'sd16775851;
      6'd7:  r = 64'sd8388437;
      6'd8:  r = 64'sd4194283;
      6'd9:  r = 64'sd2097149;
      6'd10: r = 64'sd1048576;
      default: begin
        if (i <= 6'd30) r = 64'sd1 <<< (6'd30 - i);
        else r = 64'sd0;
      end
    endcase
    return r;
  endfunction

endpackage

/* design/e2g_cordic.sv */
// ----------------------------------------------------------------------------
// e2g_cordic: iterative CORDIC, one stage per cycle
// Vectoring (drive y to zero) or rotation (drive z to zero) mode.
// ----------------------------------------------------------------------------
module e2g_cordic #(
  parameter int CordicStages = e2g_pkg::CordicStagesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  e2g_pkg::cordic_req_t req,
  output e2g_pkg::cordic_rsp_t rsp
);

  localparam int SW = $clog2(CordicStages + 1);

  logic signed [63:0] x, y, z;
  logic               mode;
  logic               busy;
  logic [SW-1:0]      stage;
  logic               done;

  logic               neg;
  logic signed [63:0] dx, dy, at;

  always_comb begin
    dx  = y >>> stage;
    dy  = x >>> stage;
    at  = e2g_pkg::atan_q30(6'(stage));
    neg = mode ? ~y[63] : z[63];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      stage <= '0;
    end else begin
      done <= busy && !req.start && (stage == SW'(CordicStages - 1));
      if (req.start) begin
        busy  <= 1'b1;
        stage <= '0;
        mode  <= req.vec_mode;
        x <= req.x0;
        y <= req.y0;
        z <= req.z0;
      end else if (busy) begin
        if (neg) begin
          x <= x + dx; y <= y - dy; z <= z + at;
        end else begin
          x <= x - dx; y <= y + dy; z <= z - at;
        end
        if (stage == SW'(CordicStages - 1)) busy <= 1'b0;
        stage <= stage + 1'b1;
      end
    end
  end

  // vectoring: y >= 0 rotates clockwise and adds the angle to z
  assign rsp.done = done;
  assign rsp.x = x;
  assign rsp.y = y;
  assign rsp.z = z;

`ifndef SYNTHESIS
  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> stage < SW'(CordicStages)) else $error("cordic stage overrun");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("cordic done not a pulse");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy)) else $error("cordic done without work");
`endif

endmodule

/* design/ecef_to_geodetic_unit.sv */
// ----------------------------------------------------------------------------
// ecef_to_geodetic_unit: ECEF position to longitude, latitude and height
// Sequencer around a shared CORDIC, a shift-add multiplier, a restoring
// divider and a bit-pair square root.
// ----------------------------------------------------------------------------
// channel  direction  handshake        payload
// in       to block   in_valid/stall   x_mm, y_mm, z_mm
// out      from block out_valid/stall  longitude, latitude, height_mm, converged
// cfg      to block   cfg_we           cfg_index, cfg_data
//
// The sequencer waits out each CORDIC run, each product on the shift-add
// multiplier, each quotient and each root. Polar-axis inputs (x and y both
// zero) go from idle through S_POLE straight to S_OUT.
// Reset clears the sequencer and sets both tolerances to 1.
// The input is stalled while busy; a result holds under out_stall.
// ----------------------------------------------------------------------------
module ecef_to_geodetic_unit #(
  parameter int MAX_ITERATIONS = e2g_pkg::MaxIterationsDefault,
  parameter int CORDIC_STAGES  = e2g_pkg::CordicStagesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [39:0] x_mm,
  input  logic signed [39:0] y_mm,
  input  logic signed [39:0] z_mm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] longitude,
  output logic signed [31:0] latitude,
  output logic signed [39:0] height_mm,
  output logic               converged
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [21:0] {
    S_IDLE   = 22'd1 << 0,
    S_VLON   = 22'd1 << 1,
    S_R0     = 22'd1 << 2,
    S_VR1    = 22'd1 << 3,
    S_R1     = 22'd1 << 4,
    S_LQ     = 22'd1 << 5,
    S_LDIV   = 22'd1 << 6,
    S_LQ2    = 22'd1 << 7,
    S_LRQ    = 22'd1 << 8,
    S_LVEC   = 22'd1 << 9,
    S_LEND   = 22'd1 << 10,
    S_SC     = 22'd1 << 11,
    S_S2     = 22'd1 << 12,
    S_W1     = 22'd1 << 13,
    S_SQRT   = 22'd1 << 14,
    S_H1     = 22'd1 << 15,
    S_H2     = 22'd1 << 16,
    S_H3     = 22'd1 << 17,
    S_POLE   = 22'd1 << 18,
    S_FIN    = 22'd1 << 19,
    S_OUT    = 22'd1 << 20,
    S_MUL    = 22'd1 << 21
  } state_t;

  state_t state, ret;
  state_t ret_mul;

  logic [9:0]  tol_h;
  logic [10:0] tol_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_h <= 10'd1;
      tol_b <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        e2g_pkg::CfgHeightTol: tol_h <= cfg_data[9:0];
        e2g_pkg::CfgLatTol:    tol_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared CORDIC
  e2g_pkg::cordic_req_t creq;
  e2g_pkg::cordic_rsp_t crsp;

  e2g_cordic #(.CordicStages(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst(rst), .req(creq), .rsp(crsp)
  );

  logic signed [63:0] zq, r0, lon, h, b, hp, bp, w, s, c, t0, t1;
  logic signed [63:0] vang;
  logic [IW-1:0]      iter;
  logic               conv;
  logic               cwait;

  // shift-add multiplier: |ma|*|mb| -> 128 bits, one bit per cycle
  logic [63:0]  ma, mb;
  logic [127:0] macc;
  logic [6:0]   mcnt;
  logic         mneg;
  logic [6:0]   mshift;
  logic         msat;
  logic signed [63:0] mres;

  always_comb begin
    logic [127:0] sh;
    sh   = macc >> mshift;
    msat = (sh[127:63] != '0);
    mres = msat ? 64'sh7FFFFFFFFFFFFFFF : $signed(sh[63:0]);
    if (mneg) mres = -mres;
  end

  // restoring divider, 64-bit unsigned
  logic [63:0] dnum, dden, dquo, drem;
  logic [6:0]  dcnt;

  // bit-pair square root
  logic [63:0] sv, sres, sbit;

  function automatic logic [63:0] umag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
      input logic signed [63:0] lo, input logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // multiplier launch, used from the sequencer
  task automatic start_mul(input logic signed [63:0] a, input logic signed [63:0] bb,
      input logic [6:0] sh, input state_t nxt);
    ma      <= umag(a);
    mb      <= umag(bb);
    mneg    <= (a[63] != bb[63]) && (a != '0) && (bb != '0);
    mshift  <= sh;
    macc    <= '0;
    mcnt    <= 7'd64;
    ret_mul <= nxt;
    state   <= S_MUL;
  endtask

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
      creq      <= '0;
      cwait     <= 1'b0;
      mcnt      <= '0;
      dcnt      <= '0;
      iter      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            zq   <= 64'(z_mm) <<< 8;
            conv <= 1'b0;
            lon  <= '0;
            if (x_mm == '0 && y_mm == '0) state <= S_POLE;
            else begin
              // vectoring on (x*2^18, y*2^18), both negated when x is negative
              creq.start    <= 1'b1;
              creq.vec_mode <= 1'b1;
              vang <= x_mm[39] ? (y_mm[39] ? -e2g_pkg::PiQ30 : e2g_pkg::PiQ30) : '0;
              creq.x0 <= (x_mm[39] ? -(64'(x_mm)) : 64'(x_mm)) <<< 18;
              creq.y0 <= (x_mm[39] ? -(64'(y_mm)) : 64'(y_mm)) <<< 18;
              creq.z0 <= '0;
              state <= S_VLON;
            end
          end
        end
        S_POLE: begin
          b <= zq[63] ? -e2g_pkg::HalfPiQ30 : e2g_pkg::HalfPiQ30;
          h <= ((zq[63] ? -zq : zq) >>> 8) - e2g_pkg::BMm;
          conv <= 1'b1;
          state <= S_OUT;
        end
        S_VLON: begin
          creq.start <= 1'b0;
          if (crsp.done) begin
            lon <= clampv(vang + crsp.z, -e2g_pkg::PiQ30, e2g_pkg::PiQ30);
            start_mul(crsp.x, e2g_pkg::InvKQ30, 7'd40, S_R0);
          end
        end
        S_R0: begin
          r0 <= mres;
          creq.start <= 1'b1;
          creq.vec_mode <= 1'b1;
          vang <= '0;
          creq.x0 <= mres <<< 10;
          creq.y0 <= zq <<< 10;
          creq.z0 <= '0;
          state <= S_VR1;
        end
        S_VR1: begin
          creq.start <= 1'b0;
          if (crsp.done) start_mul(crsp.x, e2g_pkg::InvKQ30, 7'd40, S_R1);
        end
        S_R1: begin
          h <= mres - e2g_pkg::SqrtAbQ8;
          w <= e2g_pkg::OneQ30;
          iter <= '0;
          state <= S_LQ;
        end
        // latitude_of: den = A + hc*w>>30
        S_LQ: begin
          start_mul((h < -(e2g_pkg::AQ8 / 2)) ? -(e2g_pkg::AQ8 / 2) : h, w, 7'd30, S_LDIV);
        end
        S_LDIV: begin
          if (dcnt == 7'd0 && !cwait) begin
            dnum  <= 64'(e2g_pkg::AQ8) << 22;
            dden  <= 64'(e2g_pkg::AQ8 + mres) >> 8;
            drem  <= '0;
            dquo  <= '0;
            dcnt  <= 7'd64;
            cwait <= 1'b1;
          end else if (dcnt != 7'd0) begin
            logic [64:0] tr;
            tr = {drem, dnum[63]};
            dnum <= dnum << 1;
            if (tr >= {1'b0, dden}) begin
              drem <= 64'(tr - {1'b0, dden});
              dquo <= {dquo[62:0], 1'b1};
            end else begin
              drem <= tr[63:0];
              dquo <= {dquo[62:0], 1'b0};
            end
            dcnt <= dcnt - 7'd1;
          end else begin
            cwait <= 1'b0;
            // E2 * r: r < 2^34ish, product fits; use multiplier unsigned form
            start_mul($signed(dquo), $signed(e2g_pkg::E2Q32), 7'd32, S_LQ2);
          end
        end
        S_LQ2: begin
          start_mul(r0, e2g_pkg::OneQ30 - mres, 7'd30, S_LRQ);
        end
        S_LRQ: begin
          creq.start <= 1'b1;
          creq.vec_mode <= 1'b1;
          vang <= mres[63] ? (zq[63] ? -e2g_pkg::PiQ30 : e2g_pkg::PiQ30) : '0;
          creq.x0 <= (mres[63] ? -mres : mres) <<< 10;
          creq.y0 <= (mres[63] ? -zq : zq) <<< 10;
          creq.z0 <= '0;
          state <= S_LVEC;
        end
        S_LVEC: begin
          creq.start <= 1'b0;
          if (crsp.done) begin
            bp <= b;
            b <= clampv(vang + crsp.z, -e2g_pkg::HalfPiQ30, e2g_pkg::HalfPiQ30);
            state <= S_LEND;
          end
        end
        S_LEND: begin
          // first latitude (iter 0 before any pass) has no check
          if (ret == S_H3) begin
            if (umag(hp - h) <= (64'(tol_h) << 8) && umag(bp - b) <= 64'(tol_b)) begin
              conv <= 1'b1;
              state <= S_FIN;
            end else if (iter == IW'(MAX_ITERATIONS)) state <= S_FIN;
            else state <= S_SC;
          end else state <= S_SC;
        end
        S_SC: begin
          creq.start <= 1'b1;
          creq.vec_mode <= 1'b0;
          creq.x0 <= e2g_pkg::InvKQ30 <<< 16;
          creq.y0 <= '0;
          creq.z0 <= b;
          hp <= h;
          iter <= iter + 1'b1;
          state <= S_S2;
          cwait <= 1'b1;
        end
        S_S2: begin
          creq.start <= 1'b0;
          if (cwait) begin
            if (crsp.done) begin
              cwait <= 1'b0;
              c <= clampv(crsp.x >>> 16, '0, e2g_pkg::OneQ30);
              s <= clampv(crsp.y >>> 16, -e2g_pkg::OneQ30, e2g_pkg::OneQ30);
            end
          end else start_mul(s, s, 7'd30, S_W1);
        end
        S_W1: begin
          if (!cwait) begin
            t0 <= mres;
            start_mul(mres, $signed(e2g_pkg::E2Q32), 7'd32, S_W1);
            cwait <= 1'b1;
          end else begin
            cwait <= 1'b0;
            sv   <= 64'(e2g_pkg::OneQ30 - mres) << 30;
            sres <= '0;
            sbit <= 64'd1 << 62;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sbit == '0) begin
            w <= $signed(sres);
            start_mul(r0, c, 7'd30, S_H1);
          end else begin
            if (sv >= sres + sbit) begin
              sv <= sv - (sres + sbit);
              sres <= (sres >> 1) + sbit;
            end else sres <= sres >> 1;
            sbit <= sbit >> 2;
          end
        end
        S_H1: begin
          t0 <= mres;
          start_mul(zq, s, 7'd30, S_H2);
        end
        S_H2: begin
          t1 <= mres;
          start_mul(e2g_pkg::AQ8, w, 7'd30, S_H3);
        end
        S_H3: begin
          h <= t0 + t1 - mres;
          ret <= S_H3;
          state <= S_LQ;
        end
        S_MUL: begin
          if (mcnt != 7'd0) begin
            if (mb[0]) macc <= macc + ({64'd0, ma} << (7'd64 - mcnt));
            mb <= mb >> 1;
            mcnt <= mcnt - 7'd1;
          end else state <= ret_mul;
        end
        S_FIN: begin
          h <= (h + 64'sd128) >>> 8;
          state <= S_OUT;
        end
        S_OUT: begin
          // the register frees when the previous result is taken this cycle
          if (!out_valid || !out_stall) begin
            longitude <= 33'(lon);
            latitude  <= 32'(b);
            height_mm <= 40'(clampv(h, -e2g_pkg::Lim40 - 64'sd1, e2g_pkg::Lim40));
            converged <= conv;
            out_valid <= 1'b1;
            ret       <= S_IDLE;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_iter_cap: assert property (@(posedge clk) disable iff (rst)
    iter <= IW'(MAX_ITERATIONS)) else $error("iteration cap exceeded");
`endif

endmodule
